// ----- rtl/lsc_pkg.sv -----
// Shared constants, codes and control/status types of the line segment clipper.
package lsc_pkg;

	// Window register width and default coordinate width
	localparam int WIN_BITS       = 12;
	localparam int COORD_BITS_DEF = 16;
	localparam int CFG_IDX_BITS   = 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW_WIDTH  = 1'b0,
		REG_WINDOW_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [WIN_BITS-1:0] WIDTH_RESET  = 12'd1024;
	localparam logic [WIN_BITS-1:0] HEIGHT_RESET = 12'd768;

	// Clip round limit
	localparam int              ROUND_BITS = 3;
	localparam logic [ROUND_BITS-1:0] MAX_ROUNDS = 3'd4;

	// Outcode bit positions
	typedef logic [3:0] outcode_t;
	localparam int CODE_LEFT   = 0;
	localparam int CODE_RIGHT  = 1;
	localparam int CODE_BOTTOM = 2;
	localparam int CODE_TOP    = 3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new segment
		logic start;  // latch round operands, kick the mul/div unit
		logic apply;  // write the interpolated endpoint back
		logic emit;   // load the output register
		logic keep;   // segment accepted (qualifies emit)
	} lsc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic both_in;   // both outcodes zero
		logic reject;    // outcodes share an outside bit
		logic div_done;  // interpolated quotient ready
	} lsc_sts_t;

endpackage

// ----- rtl/lsc_muldiv.sv -----
// Shared multiply then iterative restoring divide unit: trunc(a * b / c).
module lsc_muldiv #(
	parameter int OP_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [OP_BITS:0] op_a,
	input  logic signed [OP_BITS:0] op_b,
	input  logic signed [OP_BITS:0] op_c,
	output logic                 done,
	output logic signed [OP_BITS:0] quot
);

	localparam int CNT_BITS = $clog2(OP_BITS + 1);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	md_state_t             state_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;

	logic [OP_BITS-1:0]    ua_q, ub_q, uc_q;
	logic                  neg_q;
	logic [OP_BITS-1:0]    rem_q, quo_q;

	logic [OP_BITS:0]      abs_a, abs_b, abs_c;
	logic [2*OP_BITS-1:0]  prod;
	logic [OP_BITS:0]      trial, trial_diff;
	logic                  fits;
	logic [OP_BITS:0]      mag;

	// Operand magnitudes; the clipper keeps |b| <= |c|, so quotient fits OP_BITS
	assign abs_a = op_a[OP_BITS] ? (~op_a + 1'b1) : op_a;
	assign abs_b = op_b[OP_BITS] ? (~op_b + 1'b1) : op_b;
	assign abs_c = op_c[OP_BITS] ? (~op_c + 1'b1) : op_c;

	assign prod = ua_q * ub_q;

	// One quotient bit per cycle
	assign trial      = {rem_q, quo_q[OP_BITS-1]};
	assign fits       = trial >= {1'b0, uc_q};
	assign trial_diff = trial - {1'b0, uc_q};

	// Sign fix-up; zero divisor gives zero
	assign mag  = (uc_q == '0) ? '0 : {1'b0, quo_q};
	assign quot = neg_q ? $signed(~mag + 1'b1) : $signed(mag);
	assign done = done_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MD_DIV) && (cnt_q == CNT_BITS'(1));
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					state_q <= MD_DIV;
					cnt_q   <= CNT_BITS'(OP_BITS);
				end
				MD_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= MD_IDLE;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// Operand, product and shift registers
	always_ff @(posedge clk) begin
		if (start && state_q == MD_IDLE) begin
			ua_q  <= abs_a[OP_BITS-1:0];
			ub_q  <= abs_b[OP_BITS-1:0];
			uc_q  <= abs_c[OP_BITS-1:0];
			neg_q <= op_a[OP_BITS] ^ op_b[OP_BITS] ^ op_c[OP_BITS];
		end
		if (state_q == MD_MUL) begin
			{rem_q, quo_q} <= prod;
		end
		if (state_q == MD_DIV) begin
			rem_q <= fits ? trial_diff[OP_BITS-1:0] : trial[OP_BITS-1:0];
			quo_q <= {quo_q[OP_BITS-2:0], fits};
		end
	end

endmodule

// ----- rtl/lsc_datapath.sv -----
// Clipper datapath: endpoint registers, outcodes, round operands and output register.
module lsc_datapath #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsc_pkg::lsc_cmd_t              cmd,
	output lsc_pkg::lsc_sts_t              sts,
	input  logic [lsc_pkg::WIN_BITS-1:0]   win_w,
	input  logic [lsc_pkg::WIN_BITS-1:0]   win_h,
	input  logic signed [COORD_BITS-1:0]   in_x0,
	input  logic signed [COORD_BITS-1:0]   in_y0,
	input  logic signed [COORD_BITS-1:0]   in_x1,
	input  logic signed [COORD_BITS-1:0]   in_y1,
	output logic                           res_acc,
	output logic signed [COORD_BITS-1:0]   res_x0,
	output logic signed [COORD_BITS-1:0]   res_y0,
	output logic signed [COORD_BITS-1:0]   res_x1,
	output logic signed [COORD_BITS-1:0]   res_y1
);

	// Internal coordinates also hold the window edges
	localparam int CW = (COORD_BITS > lsc_pkg::WIN_BITS) ? COORD_BITS : lsc_pkg::WIN_BITS + 1;
	localparam int DW = CW + 1;

	logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic                 side_q, horiz_q;
	logic signed [CW-1:0] edge_q, base_q;

	logic                 acc_q;
	logic signed [COORD_BITS-1:0] rx0_q, ry0_q, rx1_q, ry1_q;

	logic signed [CW-1:0] edge_w, edge_h, edge_v, new_v;
	lsc_pkg::outcode_t    c0, c1, co;
	logic                 move1, horiz;
	logic signed [DW-1:0] dx, dy, op_a, op_b, op_c, md_q, sum;
	logic                 md_done;

	function automatic lsc_pkg::outcode_t f_code(
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] w,
		input logic signed [CW-1:0] h
	);
		lsc_pkg::outcode_t code;
		code = '0;
		if (x < 0) begin
			code[lsc_pkg::CODE_LEFT] = 1'b1;
		end else if (x > w) begin
			code[lsc_pkg::CODE_RIGHT] = 1'b1;
		end
		if (y < 0) begin
			code[lsc_pkg::CODE_BOTTOM] = 1'b1;
		end else if (y > h) begin
			code[lsc_pkg::CODE_TOP] = 1'b1;
		end
		return code;
	endfunction

	assign edge_w = $signed({{(CW-lsc_pkg::WIN_BITS){1'b0}}, win_w});
	assign edge_h = $signed({{(CW-lsc_pkg::WIN_BITS){1'b0}}, win_h});

	// Outcodes and trivial decisions
	assign c0 = f_code(x0_q, y0_q, edge_w, edge_h);
	assign c1 = f_code(x1_q, y1_q, edge_w, edge_h);

	assign sts.both_in  = (c0 == '0) && (c1 == '0);
	assign sts.reject   = (c0 & c1) != '0;
	assign sts.div_done = md_done;

	// Pick the outside endpoint and the edge it crosses: top, bottom, right, left
	assign move1 = (c0 == '0);
	assign co    = move1 ? c1 : c0;
	assign horiz = co[lsc_pkg::CODE_TOP] | co[lsc_pkg::CODE_BOTTOM];

	always_comb begin
		if (co[lsc_pkg::CODE_TOP]) begin
			edge_v = edge_h;
		end else if (co[lsc_pkg::CODE_BOTTOM]) begin
			edge_v = '0;
		end else if (co[lsc_pkg::CODE_RIGHT]) begin
			edge_v = edge_w;
		end else begin
			edge_v = '0;
		end
	end

	assign dx   = DW'(x1_q) - DW'(x0_q);
	assign dy   = DW'(y1_q) - DW'(y0_q);
	assign op_a = horiz ? dx : dy;
	assign op_c = horiz ? dy : dx;
	assign op_b = DW'(edge_v) - DW'(horiz ? y0_q : x0_q);

	lsc_muldiv #(
		.OP_BITS (CW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op_a   (op_a),
		.op_b   (op_b),
		.op_c   (op_c),
		.done   (md_done),
		.quot   (md_q)
	);

	// Interpolated coordinate, always between the two endpoints
	assign sum   = DW'(base_q) + md_q;
	assign new_v = sum[CW-1:0];

	// Endpoint and round registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= CW'(in_x0);
			y0_q <= CW'(in_y0);
			x1_q <= CW'(in_x1);
			y1_q <= CW'(in_y1);
		end
		if (cmd.start) begin
			side_q  <= move1;
			horiz_q <= horiz;
			edge_q  <= edge_v;
			base_q  <= horiz ? x0_q : y0_q;
		end
		if (cmd.apply) begin
			if (side_q) begin
				x1_q <= horiz_q ? new_v : edge_q;
				y1_q <= horiz_q ? edge_q : new_v;
			end else begin
				x0_q <= horiz_q ? new_v : edge_q;
				y0_q <= horiz_q ? edge_q : new_v;
			end
		end
	end

	// Output register; rejected segments read as zero
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			acc_q <= cmd.keep;
			rx0_q <= cmd.keep ? x0_q[COORD_BITS-1:0] : '0;
			ry0_q <= cmd.keep ? y0_q[COORD_BITS-1:0] : '0;
			rx1_q <= cmd.keep ? x1_q[COORD_BITS-1:0] : '0;
			ry1_q <= cmd.keep ? y1_q[COORD_BITS-1:0] : '0;
		end
	end

	assign res_acc = acc_q;
	assign res_x0  = rx0_q;
	assign res_y0  = ry0_q;
	assign res_x1  = rx1_q;
	assign res_y1  = ry1_q;

endmodule

// ----- rtl/lsc_ctrl.sv -----
// Clipper controller: transaction handshakes and clip round sequencing.
module lsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lsc_pkg::lsc_sts_t sts,
	output lsc_pkg::lsc_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_WAIT,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [lsc_pkg::ROUND_BITS-1:0]  rnd_q;
	logic                            keep_q;
	logic                            out_valid_q;
	logic                            more;

	assign more = !sts.both_in && !sts.reject && (rnd_q != lsc_pkg::MAX_ROUNDS);

	// Commands
	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.start = (state_q == S_EVAL) && more;
		cmd.apply = (state_q == S_WAIT) && sts.div_done;
		cmd.emit  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
		cmd.keep  = keep_q;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// State, round count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rnd_q       <= '0;
			keep_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// valid rises on a handover, falls when the result is taken
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rnd_q   <= '0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (sts.both_in) begin
						keep_q  <= 1'b1;
						state_q <= S_FINISH;
					end else if (!more) begin
						keep_q  <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						rnd_q   <= rnd_q + 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (sts.div_done) begin
						state_q <= S_EVAL;
					end
				end
				S_FINISH: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/line_segment_clipper_core.sv -----
// Top level of the Cohen-Sutherland line segment clipper.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_ready  start_x, start_y, end_x, end_y
//   out      out        out_valid / out_ready accepted, clipped_start_x/_y, clipped_end_x/_y
//
// Rounds: R = clip rounds (0 to 4) per segment; internal coordinates are CW bits wide,
//   CW = max(COORD_BITS, 13). The shared multiply / restoring-divide unit, one quotient
//   bit per cycle, sets the length of each round.
// Reset: asynchronous, active low; window registers return to 1024 x 768.
// Stalls: a finished result waits in the output register; the next segment is taken
//   once the current one has been handed to that register.
module line_segment_clipper_core #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lsc_pkg::WIN_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_BITS-1:0]       start_x,
	input  logic signed [COORD_BITS-1:0]       start_y,
	input  logic signed [COORD_BITS-1:0]       end_x,
	input  logic signed [COORD_BITS-1:0]       end_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic signed [COORD_BITS-1:0]       clipped_start_x,
	output logic signed [COORD_BITS-1:0]       clipped_start_y,
	output logic signed [COORD_BITS-1:0]       clipped_end_x,
	output logic signed [COORD_BITS-1:0]       clipped_end_y
);

	logic [lsc_pkg::WIN_BITS-1:0] win_w_q, win_h_q;
	lsc_pkg::lsc_cmd_t            cmd;
	lsc_pkg::lsc_sts_t            sts;

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= lsc_pkg::WIDTH_RESET;
			win_h_q <= lsc_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsc_pkg::REG_WINDOW_WIDTH:  win_w_q <= cfg_data;
				lsc_pkg::REG_WINDOW_HEIGHT: win_h_q <= cfg_data;
			endcase
		end
	end

	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsc_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.win_w   (win_w_q),
		.win_h   (win_h_q),
		.in_x0   (start_x),
		.in_y0   (start_y),
		.in_x1   (end_x),
		.in_y1   (end_y),
		.res_acc (accepted),
		.res_x0  (clipped_start_x),
		.res_y0  (clipped_start_y),
		.res_x1  (clipped_end_x),
		.res_y1  (clipped_end_y)
	);

	// Engine is busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a segment is in progress");

	// Rejected segments carry zero endpoints
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> clipped_start_x == '0 && clipped_start_y == '0 &&
			clipped_end_x == '0 && clipped_end_y == '0)
		else $error("rejected segment with nonzero endpoints");

	// Accepted endpoints never lie left of or below the window
	a_accept_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !clipped_start_x[COORD_BITS-1] &&
			!clipped_start_y[COORD_BITS-1] && !clipped_end_x[COORD_BITS-1] &&
			!clipped_end_y[COORD_BITS-1])
		else $error("accepted endpoint outside the window");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Cohen-Sutherland line segment clipper core.
`timescale 1ns / 1ps

module tb_top;

	localparam int CW         = lsc_pkg::COORD_BITS_DEF;
	localparam int WBITS      = lsc_pkg::WIN_BITS;
	localparam int CYCLE_CAP  = 1000000;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = 100;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} segment_t;

	typedef struct packed {
		logic   accepted;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} clip_result_t;

	// DUT connections
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [lsc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [WBITS-1:0]                 cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	coord_t                           start_x = '0;
	coord_t                           start_y = '0;
	coord_t                           end_x = '0;
	coord_t                           end_y = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             accepted;
	coord_t                           clipped_start_x;
	coord_t                           clipped_start_y;
	coord_t                           clipped_end_x;
	coord_t                           clipped_end_y;

	// Testbench copy of the window registers
	logic [WBITS-1:0] win_w = lsc_pkg::WIDTH_RESET;
	logic [WBITS-1:0] win_h = lsc_pkg::HEIGHT_RESET;

	segment_t     seg_pending_q[$];
	clip_result_t clip_expect_q[$];

	bit no_idle = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int segs_sent = 0;
	int results_seen = 0;
	int accepted_seen = 0;
	int mismatches = 0;
	int phases_run = 0;

	line_segment_clipper_core #(.COORD_BITS(CW)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.start_x         (start_x),
		.start_y         (start_y),
		.end_x           (end_x),
		.end_y           (end_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y)
	);

	always #5 clk = ~clk;

	// Outside-region bits of one point against the current window
	function automatic lsc_pkg::outcode_t region_code(input longint x, y, w, h);
		lsc_pkg::outcode_t code;
		code = '0;
		if (x < 0)
			code[lsc_pkg::CODE_LEFT] = 1'b1;
		else if (x > w)
			code[lsc_pkg::CODE_RIGHT] = 1'b1;
		if (y < 0)
			code[lsc_pkg::CODE_BOTTOM] = 1'b1;
		else if (y > h)
			code[lsc_pkg::CODE_TOP] = 1'b1;
		return code;
	endfunction

	// a * b / c with an exact product, truncated toward zero; |b| is first taken modulo 4 * |c|
	function automatic longint scaled_quotient(input longint a, b, c);
		longint ua, ub, uc, q;
		bit neg;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		uc = (c < 0) ? -c : c;
		if (uc == 0)
			return 0;
		ub = ub % (uc * 4);
		q = (ua * ub) / uc;
		neg = ((a < 0) != (b < 0)) != (c < 0);
		return neg ? -q : q;
	endfunction

	// Expected clipper output for one segment under the current window
	function automatic clip_result_t clip_segment(input segment_t seg);
		longint x0, y0, x1, y1, w, h, nx, ny;
		lsc_pkg::outcode_t c0, c1, co;
		int rounds;
		bit ok;
		clip_result_t res;
		x0 = seg.sx;
		y0 = seg.sy;
		x1 = seg.ex;
		y1 = seg.ey;
		w = longint'(win_w);
		h = longint'(win_h);
		rounds = 0;
		ok = 1'b0;
		while (1) begin
			c0 = region_code(x0, y0, w, h);
			c1 = region_code(x1, y1, w, h);
			if (c0 == '0 && c1 == '0) begin
				ok = 1'b1;
				break;
			end
			if ((c0 & c1) != '0 || rounds >= int'(lsc_pkg::MAX_ROUNDS))
				break;
			co = (c0 != '0) ? c0 : c1;
			// edge priority: top, bottom, right, left
			if (co[lsc_pkg::CODE_TOP]) begin
				nx = x0 + scaled_quotient(x1 - x0, h - y0, y1 - y0);
				ny = h;
			end else if (co[lsc_pkg::CODE_BOTTOM]) begin
				nx = x0 + scaled_quotient(x1 - x0, 0 - y0, y1 - y0);
				ny = 0;
			end else if (co[lsc_pkg::CODE_RIGHT]) begin
				ny = y0 + scaled_quotient(y1 - y0, w - x0, x1 - x0);
				nx = w;
			end else begin
				ny = y0 + scaled_quotient(y1 - y0, 0 - x0, x1 - x0);
				nx = 0;
			end
			if (c0 != '0) begin
				x0 = nx;
				y0 = ny;
			end else begin
				x1 = nx;
				y1 = ny;
			end
			rounds++;
		end
		res = '0;
		if (ok) begin
			res.accepted = 1'b1;
			res.sx = x0[CW-1:0];
			res.sy = y0[CW-1:0];
			res.ex = x1[CW-1:0];
			res.ey = y1[CW-1:0];
		end
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// One coordinate: 0 any value, 1 around the window, 2 corner values, 3 inside
	function automatic coord_t rand_coord(input int kind, input int lim);
		int v;
		case (kind)
			0: v = $urandom;
			1: v = int'($urandom_range(0, 3 * lim + 16)) - (lim + 8);
			2: begin
				case ($urandom_range(0, 7))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					3: v = 0;
					4: v = lim;
					5: v = lim + 1;
					6: v = 1;
					default: v = -lim - 1;
				endcase
			end
			default: v = $urandom_range(0, lim);
		endcase
		return v[CW-1:0];
	endfunction

	function automatic segment_t random_segment();
		segment_t seg;
		int r, ka, kb, w, h;
		w = int'(win_w);
		h = int'(win_h);
		r = $urandom_range(0, 99);
		if (r < 50) begin
			ka = 1;
			kb = 1;
		end else if (r < 65) begin
			ka = 3;
			kb = 0;
		end else if (r < 80) begin
			ka = 0;
			kb = 0;
		end else if (r < 90) begin
			ka = 2;
			kb = 2;
		end else begin
			ka = $urandom_range(0, 3);
			kb = $urandom_range(0, 3);
		end
		// swap roles so either endpoint may be the inside one
		if ($urandom_range(0, 1) == 1) begin
			r = ka;
			ka = kb;
			kb = r;
		end
		seg.sx = rand_coord(ka, w);
		seg.sy = rand_coord(ka, h);
		seg.ex = rand_coord(kb, w);
		seg.ey = rand_coord(kb, h);
		return seg;
	endfunction

	task automatic add_seg(input int sx, sy, ex, ey);
		segment_t seg;
		seg.sx = sx[CW-1:0];
		seg.sy = sy[CW-1:0];
		seg.ex = ex[CW-1:0];
		seg.ey = ey[CW-1:0];
		seg_pending_q.push_back(seg);
	endtask

	// Block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (seg_pending_q.size() != 0 || in_valid || clip_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One phase: optional window write, then directed and random segments
	task automatic run_phase(input logic [WBITS-1:0] w, h, input bit write_regs,
			input int directed_set, input int n_random, input bit burst);
		wait_idle();
		if (write_regs) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= lsc_pkg::REG_WINDOW_WIDTH;
			cfg_data  <= w;
			@(posedge clk);
			cfg_index <= lsc_pkg::REG_WINDOW_HEIGHT;
			cfg_data  <= h;
			@(posedge clk);
			cfg_we    <= 1'b0;
			win_w = w;
			win_h = h;
		end
		@(negedge clk);
		no_idle = burst;
		phases_run++;
		if (directed_set == 1) begin
			add_seg(10, 10, 100, 200);
			add_seg(0, 0, 1024, 768);
			add_seg(-100, 50, 500, 50);
			add_seg(500, 50, 2000, 60);
			add_seg(100, -50, 120, 700);
			add_seg(100, 100, 300, 1000);
			add_seg(-500, -500, 2000, 1500);
			add_seg(-10, -10, -5, -100);
			add_seg(2000, 2000, 3000, 900);
			// misses the top-left corner; both endpoints lie above the window
			add_seg(-100, 1000, 100, 900);
			add_seg(-32768, -32768, 32767, 32767);
			add_seg(32767, -32768, -32768, 32767);
			add_seg(-32768, 32767, -32768, 32767);
			add_seg(512, 384, 512, 384);
			add_seg(32767, 32767, 32767, 32767);
			add_seg(-1, -1, 1025, 769);
			add_seg(0, 768, 1024, 0);
			add_seg(-1, 0, -1, 768);
			add_seg(1025, 0, 1025, 768);
			add_seg(-32768, 100, 32767, 101);
			add_seg(100, -32768, 101, 32767);
			add_seg(-1, 384, 1025, 385);
		end else if (directed_set == 2) begin
			// single-point window
			add_seg(0, 0, 0, 0);
			add_seg(-5, -5, 5, 5);
			add_seg(-100, 0, 100, 0);
			add_seg(0, -100, 0, 100);
			add_seg(3, 3, 4, 4);
		end
		repeat (n_random)
			seg_pending_q.push_back(random_segment());
	endtask

	// Driver: offers queued segments, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin : drive_segments
		segment_t seg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			start_x  <= '0;
			start_y  <= '0;
			end_x    <= '0;
			end_y    <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				seg.sx = start_x;
				seg.sy = start_y;
				seg.ex = end_x;
				seg.ey = end_y;
				clip_expect_q.push_back(clip_segment(seg));
				segs_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (seg_pending_q.size() != 0) begin
					seg = seg_pending_q.pop_front();
					start_x  <= seg.sx;
					start_y  <= seg.sy;
					end_x    <= seg.ex;
					end_y    <= seg.ey;
					in_valid <= 1'b1;
					gap_left <= idle_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transaction, drives out_ready with stalls
	always @(posedge clk or negedge arst_n) begin : check_results
		clip_result_t got, want;
		bit start_hold;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			start_hold = 1'b0;
			if (out_valid && out_ready) begin
				got = {accepted, clipped_start_x, clipped_start_y, clipped_end_x,
					clipped_end_y};
				results_seen++;
				if (accepted)
					accepted_seen++;
				if (clip_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: acc=%0d (%0d,%0d)-(%0d,%0d)",
							got.accepted, got.sx, got.sy, got.ex, got.ey);
				end else begin
					want = clip_expect_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch #%0d: exp acc=%0d (%0d,%0d)-(%0d,%0d)",
								" got acc=%0d (%0d,%0d)-(%0d,%0d)"},
								results_seen, want.accepted, want.sx, want.sy, want.ex,
								want.ey, got.accepted, got.sx, got.sy, got.ex, got.ey);
					end
				end
				// long back-pressure so the core fills and stalls its input
				if (results_seen == 150 || results_seen == 700)
					start_hold = 1'b1;
			end
			if (start_hold) begin
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready  <= 1'b1;
				stall_left <= idle_length();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Test sequence
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_phase(lsc_pkg::WIDTH_RESET, lsc_pkg::HEIGHT_RESET, 1'b0, 1, 150, 1'b0);
		run_phase(12'd4095, 12'd4095, 1'b1, 0, 150, 1'b1);
		run_phase(12'd1, 12'd1, 1'b1, 0, 100, 1'b0);
		run_phase(12'd0, 12'd0, 1'b1, 2, 80, 1'b0);
		run_phase(12'd0, 12'd4095, 1'b1, 0, 80, 1'b0);
		run_phase(12'd4095, 12'd0, 1'b1, 0, 80, 1'b0);
		run_phase(WBITS'($urandom_range(1, 4095)), WBITS'($urandom_range(1, 4095)),
			1'b1, 0, 150, 1'b0);
		run_phase(WBITS'($urandom_range(1, 4095)), WBITS'($urandom_range(1, 4095)),
			1'b1, 0, 140, 1'b1);

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d segments over %0d window settings, %0d results (%0d accepted, %0d rejected)",
			segs_sent, phases_run, results_seen, accepted_seen,
			results_seen - accepted_seen);
		$display("window extremes 0 and 4095, long output back-pressure, %0d mismatches",
			mismatches);
		if (mismatches == 0 && clip_expect_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
